// ===== rtl/rset_pkg.sv =====
// rset_pkg: word types, status and action codes, micro-op and jump codes,
// and the control store of the randomized set table sequencer
// no dependencies
`default_nettype none

package rset_pkg;

    localparam int DRAW_W = 16;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_PICK   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_EXISTS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] item_value;
        logic [DRAW_W-1:0]  random_draw;
    } rset_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] picked_value;
        logic [6:0]         member_count;
    } rset_out_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN_INIT,
        OP_SCAN,
        OP_STATUS,
        OP_APPEND,
        OP_READ_LAST,
        OP_MOVE,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_READ_REM,
        OP_PICK,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        C_NEXT,
        C_GOTO,
        C_WAIT_IN,
        C_DISPATCH,
        C_SCAN,
        C_IF_FULL,
        C_IF_EMPTY,
        C_DIV_LOOP,
        C_WAIT_OUT
    } cond_t;

    typedef logic [4:0] upc_t;

    typedef struct packed {
        op_t     op;
        cond_t   cond;
        upc_t    target;
        status_t status;
    } ctrl_word_t;

    typedef struct packed {
        logic       accept;
        logic       hit;
        logic       scan_live;
        logic       full;
        logic       empty;
        logic       div_last;
        logic       out_free;
        logic [1:0] action;
    } rset_flags_t;

    localparam upc_t U_IDLE     = 5'd0;
    localparam upc_t U_DISPATCH = 5'd1;
    localparam upc_t U_INS_SCAN = 5'd2;
    localparam upc_t U_INS_CHK  = 5'd3;
    localparam upc_t U_INS_WR   = 5'd4;
    localparam upc_t U_REM_CHK  = 5'd5;
    localparam upc_t U_REM_SCAN = 5'd6;
    localparam upc_t U_NOCHANGE = 5'd7;
    localparam upc_t U_REM_HIT  = 5'd8;
    localparam upc_t U_REM_MOVE = 5'd9;
    localparam upc_t U_PICK_CHK = 5'd10;
    localparam upc_t U_PICK_DIV = 5'd11;
    localparam upc_t U_PICK_RD  = 5'd12;
    localparam upc_t U_PICK_OUT = 5'd13;
    localparam upc_t U_EMPTY    = 5'd14;
    localparam upc_t U_FULL     = 5'd15;
    localparam upc_t U_DONE     = 5'd16;

    function automatic ctrl_word_t cw(op_t op, cond_t cond, upc_t target, status_t status);
        ctrl_word_t w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        w.status = status;
        return w;
    endfunction

    // control store
    function automatic ctrl_word_t ucode_rom(upc_t addr);
        ctrl_word_t w;
        case (addr)
            U_IDLE:     w = cw(OP_LOAD,      C_WAIT_IN,  U_IDLE,     ST_DONE);
            U_DISPATCH: w = cw(OP_SCAN_INIT, C_DISPATCH, U_IDLE,     ST_DONE);
            U_INS_SCAN: w = cw(OP_SCAN,      C_SCAN,     U_NOCHANGE, ST_DONE);
            U_INS_CHK:  w = cw(OP_NONE,      C_IF_FULL,  U_FULL,     ST_DONE);
            U_INS_WR:   w = cw(OP_APPEND,    C_GOTO,     U_DONE,     ST_DONE);
            U_REM_CHK:  w = cw(OP_NONE,      C_IF_EMPTY, U_EMPTY,    ST_DONE);
            U_REM_SCAN: w = cw(OP_SCAN,      C_SCAN,     U_REM_HIT,  ST_DONE);
            U_NOCHANGE: w = cw(OP_STATUS,    C_GOTO,     U_DONE,     ST_EXISTS);
            U_REM_HIT:  w = cw(OP_READ_LAST, C_NEXT,     U_IDLE,     ST_DONE);
            U_REM_MOVE: w = cw(OP_MOVE,      C_GOTO,     U_DONE,     ST_DONE);
            U_PICK_CHK: w = cw(OP_DIV_INIT,  C_IF_EMPTY, U_EMPTY,    ST_DONE);
            U_PICK_DIV: w = cw(OP_DIV_STEP,  C_DIV_LOOP, U_IDLE,     ST_DONE);
            U_PICK_RD:  w = cw(OP_READ_REM,  C_NEXT,     U_IDLE,     ST_DONE);
            U_PICK_OUT: w = cw(OP_PICK,      C_GOTO,     U_DONE,     ST_DONE);
            U_EMPTY:    w = cw(OP_STATUS,    C_GOTO,     U_DONE,     ST_EMPTY);
            U_FULL:     w = cw(OP_STATUS,    C_GOTO,     U_DONE,     ST_FULL);
            U_DONE:     w = cw(OP_EMIT,      C_WAIT_OUT, U_IDLE,     ST_DONE);
            default:    w = cw(OP_NONE,      C_GOTO,     U_IDLE,     ST_DONE);
        endcase
        return w;
    endfunction

    // entry point of each action
    function automatic upc_t dispatch_target(logic [1:0] action);
        upc_t t;
        case (action)
            ACT_INSERT: t = U_INS_SCAN;
            ACT_REMOVE: t = U_REM_CHK;
            ACT_PICK:   t = U_PICK_CHK;
            default:    t = U_DONE;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/randomized_set_table.sv =====
// randomized_set_table: a set of distinct signed 32-bit values with insert,
// remove and random pick. Members sit packed in a CAPACITY-entry store with
// a live count. Insert and remove find a value by a linear scan of the live
// entries, one store read per cycle; remove moves the last member into the
// freed slot. Random pick reduces the supplied draw modulo the count with a
// one-bit-per-cycle restoring divider (16 steps) and reads that entry. Each
// input word gives one result word. One word is in work at a time; a finished
// result waits in the output register while the next word is taken. No
// clearing pass is needed after reset. Depends on rset_pkg, rset_sequencer and
// rset_datapath.
`default_nettype none

module randomized_set_table #(
    parameter int CAPACITY = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire rset_pkg::rset_in_t s_word,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output rset_pkg::rset_out_t     m_word
);
    import rset_pkg::*;

    ctrl_word_t  ctrl;
    rset_flags_t flags;

    rset_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    rset_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .flags   (flags),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

endmodule

`default_nettype wire

// ===== rtl/rset_sequencer.sv =====
// rset_sequencer: micro-program counter and jump logic over the control store
// depends on rset_pkg
`default_nettype none

module rset_sequencer (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire rset_pkg::rset_flags_t flags,
    output rset_pkg::ctrl_word_t      ctrl
);
    import rset_pkg::*;

    upc_t upc_reg;
    upc_t upc_next;
    upc_t upc_inc;

    assign ctrl    = ucode_rom(upc_reg);
    assign upc_inc = upc_reg + 5'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= U_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

    always_comb begin
        case (ctrl.cond)
            C_NEXT:     upc_next = upc_inc;
            C_GOTO:     upc_next = ctrl.target;
            C_WAIT_IN:  upc_next = flags.accept ? upc_inc : upc_reg;
            C_DISPATCH: upc_next = dispatch_target(flags.action);
            C_SCAN: begin
                if (flags.hit) begin
                    upc_next = ctrl.target;
                end else if (flags.scan_live) begin
                    upc_next = upc_reg;
                end else begin
                    upc_next = upc_inc;
                end
            end
            C_IF_FULL:  upc_next = flags.full ? ctrl.target : upc_inc;
            C_IF_EMPTY: upc_next = flags.empty ? ctrl.target : upc_inc;
            C_DIV_LOOP: upc_next = flags.div_last ? upc_inc : upc_reg;
            C_WAIT_OUT: upc_next = flags.out_free ? ctrl.target : upc_reg;
            default:    upc_next = U_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/rset_datapath.sv =====
// rset_datapath: member store, count, scan index, modulo unit and result register
// depends on rset_pkg; driven by the control word of rset_sequencer
`default_nettype none

module rset_datapath #(
    parameter int CAPACITY = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire rset_pkg::ctrl_word_t  ctrl,
    output rset_pkg::rset_flags_t      flags,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire rset_pkg::rset_in_t    s_word,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output rset_pkg::rset_out_t        m_word
);
    import rset_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [31:0] mem [CAPACITY];

    logic [1:0]         act_reg;
    logic signed [31:0] val_reg;
    logic [DRAW_W-1:0]  draw_reg,  draw_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg,   idx_next;
    logic               rdv_reg,   rdv_next;
    logic [AW-1:0]      pos_reg,   pos_next;
    logic [CW-1:0]      rem_reg,   rem_next;
    logic [3:0]         bitcnt_reg, bitcnt_next;
    logic [1:0]         status_reg, status_next;
    logic signed [31:0] picked_reg, picked_next;
    logic signed [31:0] rdata_reg;
    logic               m_valid_reg;
    rset_out_t          m_word_reg;

    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic signed [31:0] mem_wdata;

    logic               accept, hit, out_free, emit;
    logic [CW-1:0]      last_idx;
    logic [CW:0]        rem_ext, cnt_ext, rem_diff;
    logic [CW+6:0]      count_wide;

    assign s_ready  = (ctrl.op == OP_LOAD);
    assign accept   = s_valid && s_ready;
    assign hit      = rdv_reg && (rdata_reg == val_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = (ctrl.op == OP_EMIT) && out_free;
    assign last_idx = count_reg - CW'(1);

    assign rem_ext  = {rem_reg, draw_reg[DRAW_W-1]};
    assign cnt_ext  = {1'b0, count_reg};
    assign rem_diff = rem_ext - cnt_ext;

    assign count_wide = {7'd0, count_reg};

    assign flags.accept    = accept;
    assign flags.hit       = hit;
    assign flags.scan_live = rdv_reg || (idx_reg < count_reg);
    assign flags.full      = (count_reg >= CW'(CAPACITY));
    assign flags.empty     = (count_reg == '0);
    assign flags.div_last  = (bitcnt_reg == 4'(DRAW_W - 1));
    assign flags.out_free  = out_free;
    assign flags.action    = act_reg;

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    always_comb begin
        draw_next   = draw_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        rdv_next    = rdv_reg;
        pos_next    = pos_reg;
        rem_next    = rem_reg;
        bitcnt_next = bitcnt_reg;
        status_next = status_reg;
        picked_next = picked_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = count_reg[AW-1:0];
        mem_raddr   = idx_reg[AW-1:0];
        mem_wdata   = val_reg;
        case (ctrl.op)
            OP_LOAD: begin
                draw_next = s_word.random_draw;
            end
            OP_SCAN_INIT: begin
                idx_next    = '0;
                rdv_next    = 1'b0;
                status_next = ST_DONE;
                picked_next = '0;
            end
            OP_SCAN: begin
                if (!hit) begin
                    mem_re   = 1'b1;
                    rdv_next = (idx_reg < count_reg);
                    pos_next = idx_reg[AW-1:0];
                    if (idx_reg < count_reg) begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
            end
            OP_STATUS: begin
                status_next = ctrl.status;
            end
            OP_APPEND: begin
                mem_we     = 1'b1;
                count_next = count_reg + CW'(1);
            end
            OP_READ_LAST: begin
                mem_re     = 1'b1;
                mem_raddr  = last_idx[AW-1:0];
                count_next = last_idx;
                rdv_next   = 1'b0;
            end
            OP_MOVE: begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg;
                mem_wdata = rdata_reg;
            end
            OP_DIV_INIT: begin
                rem_next    = '0;
                bitcnt_next = '0;
            end
            OP_DIV_STEP: begin
                // one restoring step per draw bit, msb first
                if (rem_ext >= cnt_ext) begin
                    rem_next = CW'(rem_diff);
                end else begin
                    rem_next = rem_ext[CW-1:0];
                end
                draw_next   = {draw_reg[DRAW_W-2:0], 1'b0};
                bitcnt_next = bitcnt_reg + 4'd1;
            end
            OP_READ_REM: begin
                mem_re    = 1'b1;
                mem_raddr = rem_reg[AW-1:0];
            end
            OP_PICK: begin
                picked_next = rdata_reg;
            end
            default: begin
            end
        endcase
    end

    // member store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            rdv_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            rdv_reg   <= rdv_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg <= s_word.action;
            val_reg <= s_word.item_value;
        end
        draw_reg   <= draw_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        rem_reg    <= rem_next;
        bitcnt_reg <= bitcnt_next;
        status_reg <= status_next;
        picked_reg <= picked_next;
        if (emit) begin
            m_word_reg.status       <= status_reg;
            m_word_reg.picked_value <= picked_reg;
            m_word_reg.member_count <= count_wide[6:0];
        end
    end

endmodule

`default_nettype wire

// ===== sim/tb_randomized_set_table.sv =====
// tb_randomized_set_table: self-checking testbench for the randomized set table
// drives insert, remove and pick words through valid/ready and checks each result word
// depends on rset_pkg and randomized_set_table
`timescale 1ns / 1ps

module tb_randomized_set_table;
    import rset_pkg::*;

    localparam int SET_CAPACITY   = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 100;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    rset_in_t  s_word  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    rset_out_t m_word;

    rset_in_t           queued_ops[$];
    rset_out_t          pending_replies[$];
    logic signed [31:0] value_pool[$];
    logic signed [31:0] shadow_members[SET_CAPACITY];
    int                 shadow_count = 0;
    int                 idle_level   = 0;
    int                 send_gap     = 0;
    int                 recv_stall   = 0;
    int                 quiet_cycles = 0;
    int                 mismatches   = 0;
    int                 words_seen   = 0;
    rset_out_t          oldest;

    randomized_set_table #(
        .CAPACITY(SET_CAPACITY)
    ) u_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_word (s_word),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_word (m_word)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // applies one word to the shadow set and returns the result word it owes
    function automatic rset_out_t apply_set_op(rset_in_t w);
        rset_out_t reply;
        int        hit_at;
        int        i;
        reply  = '0;
        hit_at = -1;
        for (i = 0; i < shadow_count; i++) begin
            if (hit_at < 0 && shadow_members[i] == w.item_value)
                hit_at = i;
        end
        case (w.action)
            ACT_INSERT: begin
                if (hit_at >= 0)
                    reply.status = ST_EXISTS;
                else if (shadow_count >= SET_CAPACITY)
                    reply.status = ST_FULL;
                else begin
                    shadow_members[shadow_count] = w.item_value;
                    shadow_count++;
                end
            end
            ACT_REMOVE: begin
                if (shadow_count == 0)
                    reply.status = ST_EMPTY;
                else if (hit_at < 0)
                    reply.status = ST_EXISTS;
                else begin
                    shadow_members[hit_at] = shadow_members[shadow_count - 1];
                    shadow_count--;
                end
            end
            ACT_PICK: begin
                if (shadow_count == 0)
                    reply.status = ST_EMPTY;
                else
                    reply.picked_value = shadow_members[int'(w.random_draw) % shadow_count];
            end
            default: begin
            end
        endcase
        reply.member_count = shadow_count[6:0];
        return reply;
    endfunction

    function automatic bit idle_roll();
        case (idle_level)
            0:       return 1'b0;
            1:       return $urandom_range(0, 15) == 0;
            default: return $urandom_range(0, 2) == 0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("word %0d: %s is %0d, want %0d", words_seen, what, got, want);
        mismatches++;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready)
                pending_replies = {pending_replies, apply_set_op(s_word)};
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (queued_ops.size() != 0) begin
                    s_word  <= queued_ops.pop_front();
                    s_valid <= 1'b1;
                    if (idle_roll())
                        send_gap <= $urandom_range(1, 14);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_replies.size() == 0) begin
                    report_mismatch("status of unexpected word", m_word.status, 0);
                end else begin
                    oldest = pending_replies.pop_front();
                    if (m_word.status != oldest.status)
                        report_mismatch("status", m_word.status, oldest.status);
                    if (m_word.picked_value != oldest.picked_value)
                        report_mismatch("picked_value", longint'(m_word.picked_value),
                                        longint'(oldest.picked_value));
                    if (m_word.member_count != oldest.member_count)
                        report_mismatch("member_count", m_word.member_count,
                                        oldest.member_count);
                end
                words_seen++;
            end
            if (recv_stall != 0) begin
                recv_stall <= recv_stall - 1;
                m_ready    <= 1'b0;
            end else if (idle_roll()) begin
                recv_stall <= $urandom_range(0, 13);
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb_randomized_set_table NOT OK");
            $finish;
        end
    end

    task automatic queue_word(input action_t act, input logic signed [31:0] val,
                              input logic [15:0] draw);
        rset_in_t w;
        w.action      = act;
        w.item_value  = val;
        w.random_draw = draw;
        queued_ops    = {queued_ops, w};
    endtask

    function automatic logic [15:0] any_draw();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 130));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [31:0] pool_value();
        return value_pool[$urandom_range(0, value_pool.size() - 1)];
    endfunction

    task automatic refill_pool(input int n);
        int                 k;
        logic signed [31:0] v;
        value_pool.delete();
        for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 15))
                0:       v = 32'sh80000000;
                1:       v = 32'sh7FFFFFFF;
                2, 3:    v = int'($urandom_range(0, 31)) - 16;
                default: v = $urandom;
            endcase
            value_pool = {value_pool, v};
        end
    endtask

    task automatic shuffle_pool();
        int                 i;
        int                 j;
        logic signed [31:0] t;
        for (i = value_pool.size() - 1; i > 0; i--) begin
            j             = $urandom_range(0, i);
            t             = value_pool[i];
            value_pool[i] = value_pool[j];
            value_pool[j] = t;
        end
    endtask

    // insert every pool value, more than the table holds
    task automatic fill_ops();
        int k;
        shuffle_pool();
        for (k = 0; k < value_pool.size(); k++) begin
            queue_word(ACT_INSERT, value_pool[k], any_draw());
            if ($urandom_range(0, 3) == 0)
                queue_word(ACT_PICK, $urandom, any_draw());
            if ($urandom_range(0, 7) == 0)
                queue_word(ACT_INSERT, value_pool[$urandom_range(0, k)], any_draw());
        end
    endtask

    task automatic mixed_ops(input int n);
        int k;
        int r;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 19);
            if (r <= 6)
                queue_word(ACT_INSERT, pool_value(), any_draw());
            else if (r <= 12)
                queue_word(ACT_REMOVE, pool_value(), any_draw());
            else if (r == 13)
                queue_word(ACT_REMOVE, $urandom, any_draw());
            else if (r <= 18)
                queue_word(ACT_PICK, $urandom, any_draw());
            else
                queue_word(ACT_NONE, $urandom, any_draw());
        end
    endtask

    // remove every pool value, leaving the table empty
    task automatic drain_ops();
        int k;
        shuffle_pool();
        for (k = 0; k < value_pool.size(); k++) begin
            queue_word(ACT_REMOVE, value_pool[k], any_draw());
            if ($urandom_range(0, 3) == 0)
                queue_word(ACT_PICK, $urandom, any_draw());
        end
        queue_word(ACT_REMOVE, $urandom, any_draw());
        queue_word(ACT_REMOVE, value_pool[0], any_draw());
        queue_word(ACT_PICK, $urandom, any_draw());
    endtask

    task automatic wait_drained(input bit with_replies);
        while (queued_ops.size() != 0 || s_valid ||
               (with_replies && pending_replies.size() != 0))
            @(negedge aclk);
    endtask

    initial begin
        int round;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty set, extremes, duplicates, swap on remove
        queue_word(ACT_PICK,   32'sd0,           16'h0000);
        queue_word(ACT_REMOVE, 32'sd5,           16'h0000);
        queue_word(ACT_NONE,   -32'sd1,          16'hFFFF);
        queue_word(ACT_INSERT, 32'sh80000000,    16'h0000);
        queue_word(ACT_INSERT, 32'sh7FFFFFFF,    16'hFFFF);
        queue_word(ACT_INSERT, -32'sd1,          16'h0000);
        queue_word(ACT_INSERT, 32'sd0,           16'h0000);
        queue_word(ACT_INSERT, 32'sh7FFFFFFF,    16'h0000);
        queue_word(ACT_PICK,   32'sd0,           16'h0000);
        queue_word(ACT_PICK,   32'sd0,           16'hFFFF);
        queue_word(ACT_PICK,   32'sd0,           16'h0002);
        queue_word(ACT_REMOVE, 32'sd12345,       16'h0000);
        queue_word(ACT_REMOVE, 32'sd0,           16'h0000);
        queue_word(ACT_REMOVE, 32'sh80000000,    16'h0000);
        queue_word(ACT_PICK,   32'sd0,           16'h0001);
        queue_word(ACT_NONE,   32'sh7FFFFFFF,    16'h5555);
        queue_word(ACT_REMOVE, -32'sd1,          16'h0000);
        queue_word(ACT_REMOVE, 32'sh7FFFFFFF,    16'h0000);
        queue_word(ACT_PICK,   32'sd0,           16'hFFFF);
        queue_word(ACT_REMOVE, 32'sh7FFFFFFF,    16'h0000);
        wait_drained(1'b1);

        for (round = 0; round < 4; round++) begin
            refill_pool(76);
            idle_level = $urandom_range(0, 2);
            fill_ops();
            wait_drained(1'b0);
            idle_level = $urandom_range(0, 2);
            mixed_ops(160);
            wait_drained(1'b0);
            idle_level = $urandom_range(0, 2);
            drain_ops();
            // sender holds off until the table has answered everything
            wait_drained(1'b1);
        end

        idle_level = 0;
        refill_pool(40);
        mixed_ops(110);
        wait_drained(1'b1);
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (mismatches == 0 && pending_replies.size() == 0)
            $display("tb_randomized_set_table OK");
        else
            $display("tb_randomized_set_table NOT OK");
        $finish;
    end

endmodule
